### rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Result kind codes, the internal case selector and the fixed result width.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// Width of one root on the result channel, signed fixed point.
	localparam int OUT_W = 34;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_ALL  = 2'd3
	} root_kind_t;

	// Which formula applies to a coefficient set.
	typedef enum logic [2:0] {
		MODE_NONE = 3'd0,
		MODE_ALL  = 3'd1,
		MODE_TWO  = 3'd2,
		MODE_LIN  = 3'd3,
		MODE_DBL  = 3'd4
	} mode_t;

	localparam int MODE_W = 3;

endpackage

### rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit method; floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module qrs_sqrt #(
	parameter int RAD_W  = 66,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output logic [SIDE_W-1:0]    out_side
);
	localparam int SW  = RAD_W / 2;
	localparam int RMW = SW + 2;

	logic              vld  [0:SW];
	logic [RAD_W-1:0]  rad  [0:SW];
	logic [RMW-1:0]    rem  [0:SW];
	logic [SW-1:0]     rt   [0:SW];
	logic [SIDE_W-1:0] side [0:SW];

	assign vld[0]  = in_valid;
	assign rad[0]  = radicand;
	assign rem[0]  = '0;
	assign rt[0]   = '0;
	assign side[0] = in_side;

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [RMW-1:0] rem_sh;
		logic [RMW-1:0] trial;
		logic           fit;

		// Bring down the next two radicand bits and try appending a one.
		assign rem_sh = {rem[k][RMW-3:0], rad[k][RAD_W-1 -: 2]};
		assign trial  = {rt[k], 2'b01};
		assign fit    = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad[k+1]  <= rad[k] << 2;
				rem[k+1]  <= fit ? rem_sh - trial : rem_sh;
				rt[k+1]   <= {rt[k][SW-2:0], fit};
				side[k+1] <= side[k];
			end
		end
	end

	assign out_valid = vld[SW];
	assign root      = rt[SW];
	assign out_side  = side[SW] ^ SIDE_W'(rad[SW][0] & rem[SW][0] & 1'b0);

endmodule

### rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: pipelined two-lane unsigned divider
// Restoring division, one quotient bit per stage; both lanes share a divisor.
// ----------------------------------------------------------------------------
module qrs_div #(
	parameter int Q_W    = 36,
	parameter int D_W    = 18,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [Q_W-1:0]    num0,
	input  logic [Q_W-1:0]    num1,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo0,
	output logic [Q_W-1:0]    quo1,
	output logic [SIDE_W-1:0] out_side
);
	logic              vld  [0:Q_W];
	logic [Q_W-1:0]    nq0  [0:Q_W];
	logic [Q_W-1:0]    nq1  [0:Q_W];
	logic [D_W-1:0]    r0   [0:Q_W];
	logic [D_W-1:0]    r1   [0:Q_W];
	logic [D_W-1:0]    dd   [0:Q_W];
	logic [SIDE_W-1:0] side [0:Q_W];

	assign vld[0]  = in_valid;
	assign nq0[0]  = num0;
	assign nq1[0]  = num1;
	assign r0[0]   = '0;
	assign r1[0]   = '0;
	assign dd[0]   = den;
	assign side[0] = in_side;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [D_W:0] sh0, sh1, df0, df1;
		logic         fit0, fit1;

		// The numerator register shifts out dividend bits and shifts in quotient bits.
		assign sh0  = {r0[k], nq0[k][Q_W-1]};
		assign sh1  = {r1[k], nq1[k][Q_W-1]};
		assign df0  = sh0 - {1'b0, dd[k]};
		assign df1  = sh1 - {1'b0, dd[k]};
		assign fit0 = sh0 >= {1'b0, dd[k]};
		assign fit1 = sh1 >= {1'b0, dd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r0[k+1]   <= fit0 ? df0[D_W-1:0] : sh0[D_W-1:0];
				r1[k+1]   <= fit1 ? df1[D_W-1:0] : sh1[D_W-1:0];
				nq0[k+1]  <= {nq0[k][Q_W-2:0], fit0};
				nq1[k+1]  <= {nq1[k][Q_W-2:0], fit1};
				dd[k+1]   <= dd[k];
				side[k+1] <= side[k];
			end
		end
	end

	assign out_valid = vld[Q_W];
	assign quo0      = nq0[Q_W];
	assign quo1      = nq1[Q_W];
	assign out_side  = side[Q_W] ^ SIDE_W'(r0[Q_W][0] & r1[Q_W][0] & dd[Q_W][0] & 1'b0);

endmodule

### rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c
// Fully pipelined solver, one coefficient set per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
// A request on the s_ channel carries signed coefficients a, b and c. Every
// request yields exactly one result on the m_ channel: the root kind in
// m_tuser and the two roots in m_tdata, signed fixed point with FRAC_BITS
// fraction bits, rounded to nearest (ties away from zero) and saturated to
// 34 bits. Two roots come smaller first; unused root fields read zero.
// The pipeline has two front stages for the products and the discriminant,
// one stage per root bit in the square root, three operand stages, one
// stage per quotient bit in the divider and two output stages. A new
// request is taken every cycle. When the receiver holds off m_tready with a
// result waiting, the whole pipeline freezes and s_tready falls in the same
// cycle; nothing is lost or repeated. Reset clears the valid bits only, and
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]         s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// root_low, root_high from bit 0 up, zero padded to bytes
	output logic [((2*qrs_pkg::OUT_W+7)/8)*8-1:0]     m_tdata,
	// root_kind
	output qrs_pkg::root_kind_t                       m_tuser
);
	import qrs_pkg::*;

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int DW     = 2*W + 3;
	localparam int DMW    = 2*W + 2;
	localparam int RW     = DMW + 2*F;
	localparam int SW     = RW / 2;
	localparam int NSW    = W + F + 3;
	localparam int UNW    = W + F + 2;
	localparam int DSW    = W + 2;
	localparam int UDW    = W + 1;
	localparam int QW     = W + F + 4;
	localparam int DDW    = W + 2;
	localparam int EW     = (QW > OUT_W) ? QW : OUT_W;
	localparam int OUT_TW = ((2*OUT_W+7)/8)*8;
	localparam int SQ_SW  = MODE_W + 3*W;
	localparam int DV_SW  = MODE_W + 2;

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: products.
	logic signed [W-1:0]   a_in, b_in, c_in;
	logic                  valid_s1;
	logic signed [W-1:0]   a_s1, b_s1, c_s1;
	logic signed [2*W-1:0] bb_s1, ac_s1;

	assign a_in = $signed(s_tdata[W-1:0]);
	assign b_in = $signed(s_tdata[2*W-1:W]);
	assign c_in = $signed(s_tdata[3*W-1:2*W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= a_in;
			b_s1  <= b_in;
			c_s1  <= c_in;
			bb_s1 <= b_in * b_in;
			ac_s1 <= a_in * c_in;
		end
	end

	// Stage 2: discriminant and case selection.
	logic signed [DW-1:0] delta_c;
	logic                 dpos, dzero;
	mode_t                mode_c;
	logic                 valid_s2;
	logic signed [W-1:0]  a_s2, b_s2, c_s2;
	mode_t                mode_s2;
	logic [RW-1:0]        rad_s2;

	assign delta_c = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign dzero   = delta_c == '0;
	assign dpos    = !delta_c[DW-1] && !dzero;

	always_comb begin
		mode_c = MODE_NONE;
		if (dpos) begin
			mode_c = (a_s1 != '0) ? MODE_TWO : MODE_LIN;
		end else if (dzero) begin
			if (a_s1 == '0 && c_s1 == '0) begin
				mode_c = MODE_ALL;
			end else if (a_s1 != '0) begin
				mode_c = MODE_DBL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			mode_s2 <= mode_c;
			rad_s2  <= (mode_c == MODE_TWO) ? {delta_c[DMW-1:0], {(2*F){1'b0}}} : '0;
		end
	end

	// Square root of delta * 2^(2F) for two distinct roots, of zero otherwise.
	logic             sq_valid;
	logic [SW-1:0]    sq_root;
	logic [SQ_SW-1:0] sq_side;

	qrs_sqrt #(
		.RAD_W  (RW),
		.SIDE_W (SQ_SW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s2),
		.radicand  (rad_s2),
		.in_side   ({mode_s2, a_s2, b_s2, c_s2}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// Stage 3: signed numerators and divisor.
	mode_t                sq_mode;
	logic signed [W-1:0]  sq_a, sq_b, sq_c;
	logic signed [NSW-1:0] bs, cs, sx;
	logic                 valid_s3;
	mode_t                mode_s3;
	logic signed [NSW-1:0] n0_s3, n1_s3;
	logic signed [DSW-1:0] d_s3;

	assign sq_mode = mode_t'(sq_side[SQ_SW-1 -: MODE_W]);
	assign sq_a    = $signed(sq_side[3*W-1:2*W]);
	assign sq_b    = $signed(sq_side[2*W-1:W]);
	assign sq_c    = $signed(sq_side[W-1:0]);
	assign bs      = NSW'(sq_b) <<< F;
	assign cs      = NSW'(sq_c) <<< F;
	assign sx      = $signed(NSW'(sq_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= sq_mode;
			n0_s3   <= (sq_mode == MODE_LIN) ? -cs : -bs - sx;
			n1_s3   <= -bs + sx;
			d_s3    <= (sq_mode == MODE_LIN) ? DSW'(sq_b) : (DSW'(sq_a) <<< 1);
		end
	end

	// Stage 4: magnitudes and result signs.
	logic signed [NSW-1:0] an0, an1;
	logic signed [DSW-1:0] ad;
	logic                  valid_s4;
	mode_t                 mode_s4;
	logic [UNW-1:0]        un0_s4, un1_s4;
	logic [UDW-1:0]        ud_s4;
	logic                  neg0_s4, neg1_s4;

	assign an0 = n0_s3[NSW-1] ? -n0_s3 : n0_s3;
	assign an1 = n1_s3[NSW-1] ? -n1_s3 : n1_s3;
	assign ad  = d_s3[DSW-1] ? -d_s3 : d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s4 <= mode_s3;
			un0_s4  <= an0[UNW-1:0];
			un1_s4  <= an1[UNW-1:0];
			ud_s4   <= ad[UDW-1:0];
			neg0_s4 <= n0_s3[NSW-1] ^ d_s3[DSW-1];
			neg1_s4 <= n1_s3[NSW-1] ^ d_s3[DSW-1];
		end
	end

	// Stage 5: rounding is folded into the division as (2n + d) / 2d.
	logic             valid_s5;
	logic [DV_SW-1:0] side_s5;
	logic [QW-1:0]    num0_s5, num1_s5;
	logic [DDW-1:0]   den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= {mode_s4, neg0_s4, neg1_s4};
			num0_s5 <= (QW'(un0_s4) << 1) + QW'(ud_s4);
			num1_s5 <= (QW'(un1_s4) << 1) + QW'(ud_s4);
			den_s5  <= DDW'(ud_s4) << 1;
		end
	end

	logic             dv_valid;
	logic [QW-1:0]    dv_q0, dv_q1;
	logic [DV_SW-1:0] dv_side;

	qrs_div #(
		.Q_W    (QW),
		.D_W    (DDW),
		.SIDE_W (DV_SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s5),
		.num0      (num0_s5),
		.num1      (num1_s5),
		.den       (den_s5),
		.in_side   (side_s5),
		.out_valid (dv_valid),
		.quo0      (dv_q0),
		.quo1      (dv_q1),
		.out_side  (dv_side)
	);

	// Stage 6: sign and saturation.
	function automatic logic signed [OUT_W-1:0] sat_root(
		input logic [QW-1:0] q,
		input logic          neg
	);
		logic [EW-1:0]    qe;
		logic [OUT_W-1:0] lim;
		logic             sat;
		qe  = EW'(q);
		sat = qe >= (EW'(1) << (OUT_W-1));
		lim = OUT_W'(1) << (OUT_W-1);
		if (neg) begin
			return sat ? lim : -qe[OUT_W-1:0];
		end
		return sat ? ~lim : qe[OUT_W-1:0];
	endfunction

	logic                    valid_s6;
	mode_t                   mode_s6;
	logic signed [OUT_W-1:0] r0_s6, r1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s6 <= mode_t'(dv_side[DV_SW-1 -: MODE_W]);
			r0_s6   <= sat_root(dv_q0, dv_side[1]);
			r1_s6   <= sat_root(dv_q1, dv_side[0]);
		end
	end

	// Stage 7: ordering and the output register.
	logic                    valid_s7;
	root_kind_t              kind_s7;
	logic signed [OUT_W-1:0] lo_s7, hi_s7;
	root_kind_t              kind_c;
	logic signed [OUT_W-1:0] lo_c, hi_c;

	always_comb begin
		kind_c = KIND_NONE;
		lo_c   = '0;
		hi_c   = '0;
		case (mode_s6)
			MODE_TWO: begin
				kind_c = KIND_TWO;
				lo_c   = (r0_s6 < r1_s6) ? r0_s6 : r1_s6;
				hi_c   = (r0_s6 < r1_s6) ? r1_s6 : r0_s6;
			end
			MODE_LIN, MODE_DBL: begin
				kind_c = KIND_ONE;
				lo_c   = r0_s6;
			end
			MODE_ALL: begin
				kind_c = KIND_ALL;
			end
			default: begin
				kind_c = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s7 <= kind_c;
			lo_s7   <= lo_c;
			hi_s7   <= hi_c;
		end
	end

	assign m_tvalid = valid_s7;
	assign m_tuser  = kind_s7;
	assign m_tdata  = OUT_TW'({hi_s7, lo_s7});

`ifndef SYNTHESIS
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_ALL)
		|-> lo_s7 == '0 && hi_s7 == '0)
		else $error("root fields not zero for a result without roots");

	a_single_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ONE |-> hi_s7 == '0)
		else $error("second root not zero for a single root");

	a_two_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_TWO |-> lo_s7 <= hi_s7)
		else $error("two roots out of order");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s6) && $stable(valid_s2) && $stable(lo_s7))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule
